[design/text_whitespace_case_filter_defines.svh]
// ---------------------------------------------------------------------------
// Text whitespace and case filter: assertion macros
// Concurrent assertion helpers clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef TEXT_WHITESPACE_CASE_FILTER_DEFINES_SVH
`define TEXT_WHITESPACE_CASE_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWCF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TWCF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/twcf_pkg.sv]
// ---------------------------------------------------------------------------
// Text whitespace and case filter: package
// Character codes, register indexes and shared widths.
// ---------------------------------------------------------------------------
`default_nettype none

package twcf_pkg;

  localparam int CharWidth     = 8;
  localparam int CfgIndexWidth = 8;
  localparam int CfgDataWidth  = 8;

  typedef logic [CharWidth-1:0]     char_t;
  typedef logic [CfgIndexWidth-1:0] cfg_index_t;
  typedef logic [CfgDataWidth-1:0]  cfg_data_t;

  localparam char_t CH_BLANK  = 8'h20;
  localparam char_t CH_DQUOTE = 8'h22;
  localparam char_t CH_SQUOTE = 8'h27;
  localparam char_t CH_DEL    = 8'h7F;
  localparam char_t CASE_BIT  = 8'h20;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_DROP_ALL_WHITE     = 8'd0,
    REG_DROP_LEADING_WHITE = 8'd1,
    REG_REDUCE_WHITE_RUNS  = 8'd2,
    REG_HONOR_QUOTES       = 8'd3,
    REG_MAKE_UPPER         = 8'd4,
    REG_MAKE_LOWER         = 8'd5,
    REG_DROP_CONTROL       = 8'd6,
    REG_SWAP_CASE          = 8'd7
  } reg_index_t;

  typedef struct packed {
    logic drop_all_white;
    logic drop_leading_white;
    logic reduce_white_runs;
    logic honor_quotes;
    logic make_upper;
    logic make_lower;
    logic drop_control;
    logic swap_case;
  } mode_t;

endpackage

`default_nettype wire

[design/text_whitespace_case_filter.sv]
// ---------------------------------------------------------------------------
// Text whitespace and case filter
// Filters a byte stream one beat at a time: whitespace removal or reduction,
// control character removal, ASCII case conversion and verbatim quotes.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Payload
//   s_axis   in         tdata[7:0] in_char, tlast in_last
//   m_axis   out        tdata[7:0] out_char, tuser out_valid, tlast out_last
//   cfg      in         cfg_index register number, cfg_data bit 0 value
//
// Every input beat yields exactly one output beat in the next cycle, so
// the filter sustains one byte per cycle unless m_axis stalls. The output
// register is refilled in the cycle it is emptied. A stall on m_axis holds
// s_axis_tready low until the waiting beat is taken. The rst input clears
// the modes and the text state; the state also clears after a tlast beat.
//
`default_nettype none

`include "text_whitespace_case_filter_defines.svh"

module text_whitespace_case_filter (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire twcf_pkg::char_t     s_axis_tdata,  // [7:0] in_char
  input  wire logic                s_axis_tlast,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output twcf_pkg::char_t          m_axis_tdata,  // [7:0] out_char
  output logic                     m_axis_tuser,  // [0] out_valid
  output logic                     m_axis_tlast,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire twcf_pkg::cfg_index_t cfg_index,
  input  wire twcf_pkg::cfg_data_t  cfg_data
);
  import twcf_pkg::*;

  mode_t mode;
  logic  in_quote, quote_is_single, in_white_run, seen_nonwhite;
  logic  in_quote_next, quote_is_single_next, in_white_run_next, seen_nonwhite_next;
  logic  emit;
  char_t oc;
  logic  s_beat, is_white, is_ctrl, is_quote;

  function automatic char_t convert_case(char_t c, mode_t m);
    char_t r;
    r = c;
    if (m.make_upper && (r inside {[8'h61:8'h7A]})) r = r & ~CASE_BIT;
    if (m.make_lower && (r inside {[8'h41:8'h5A]})) r = r | CASE_BIT;
    if (m.swap_case && ((r inside {[8'h61:8'h7A]}) || (r inside {[8'h41:8'h5A]}))) begin
      r = r ^ CASE_BIT;
    end
    return r;
  endfunction

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_beat        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DROP_ALL_WHITE:     mode.drop_all_white     <= cfg_data[0];
        REG_DROP_LEADING_WHITE: mode.drop_leading_white <= cfg_data[0];
        REG_REDUCE_WHITE_RUNS:  mode.reduce_white_runs  <= cfg_data[0];
        REG_HONOR_QUOTES:       mode.honor_quotes       <= cfg_data[0];
        REG_MAKE_UPPER:         mode.make_upper         <= cfg_data[0];
        REG_MAKE_LOWER:         mode.make_lower         <= cfg_data[0];
        REG_DROP_CONTROL:       mode.drop_control       <= cfg_data[0];
        REG_SWAP_CASE:          mode.swap_case          <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    is_white = (s_axis_tdata == CH_BLANK) || (s_axis_tdata inside {[8'h09:8'h0D]});
    is_ctrl  = (s_axis_tdata < CH_BLANK) || (s_axis_tdata == CH_DEL);
    is_quote = (s_axis_tdata == CH_DQUOTE) || (s_axis_tdata == CH_SQUOTE);
    emit                 = 1'b0;
    oc                   = s_axis_tdata;
    in_quote_next        = in_quote;
    quote_is_single_next = quote_is_single;
    in_white_run_next    = in_white_run;
    seen_nonwhite_next   = seen_nonwhite;
    if (in_quote) begin
      emit = 1'b1;
      if (s_axis_tdata == (quote_is_single ? CH_SQUOTE : CH_DQUOTE)) in_quote_next = 1'b0;
    end else if (mode.honor_quotes && is_quote) begin
      emit                 = 1'b1;
      in_white_run_next    = 1'b0;
      seen_nonwhite_next   = 1'b1;
      in_quote_next        = 1'b1;
      quote_is_single_next = (s_axis_tdata == CH_SQUOTE);
    end else if (is_white) begin
      if (mode.drop_all_white) begin
        emit = 1'b0;
      end else if (mode.drop_leading_white && !seen_nonwhite) begin
        emit = 1'b0;
      end else if (mode.reduce_white_runs) begin
        if (!in_white_run) begin
          emit              = 1'b1;
          oc                = CH_BLANK;
          in_white_run_next = 1'b1;
        end
      end else begin
        emit = !(mode.drop_control && is_ctrl);
      end
    end else if (is_ctrl) begin
      in_white_run_next  = 1'b0;
      seen_nonwhite_next = 1'b1;
      emit               = !mode.drop_control;
    end else begin
      in_white_run_next  = 1'b0;
      seen_nonwhite_next = 1'b1;
      emit               = 1'b1;
      if (!s_axis_tdata[CharWidth-1]) oc = convert_case(s_axis_tdata, mode);
    end
    if (s_axis_tlast) begin
      in_quote_next        = 1'b0;
      quote_is_single_next = 1'b0;
      in_white_run_next    = 1'b0;
      seen_nonwhite_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quote        <= 1'b0;
      quote_is_single <= 1'b0;
      in_white_run    <= 1'b0;
      seen_nonwhite   <= 1'b0;
    end else if (s_beat) begin
      in_quote        <= in_quote_next;
      quote_is_single <= quote_is_single_next;
      in_white_run    <= in_white_run_next;
      seen_nonwhite   <= seen_nonwhite_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_beat) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_beat) begin
      m_axis_tuser <= emit;
      m_axis_tdata <= emit ? oc : '0;
      m_axis_tlast <= s_axis_tlast;
    end
  end

  `TWCF_ASSERT_NXT(a_last_clears, s_beat && s_axis_tlast, !in_quote && !in_white_run && !seen_nonwhite, "state not cleared after last beat")
  `TWCF_ASSERT_NXT(a_beat_fills, s_beat, m_axis_tvalid, "accepted beat gave no output beat")
  `TWCF_ASSERT_IMP(a_quiet_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "suppressed beat carries data")
  `TWCF_ASSERT_IMP(a_quote_no_run, in_quote, !in_white_run, "whitespace run open inside quotes")

endmodule

`default_nettype wire
